// ----- sv/sfls_pkg.sv -----
// Shared types and constants for the supervision frame link setup block.
`default_nettype none
package sfls_pkg;

  localparam int FRAME_BYTES = 5;
  localparam int IDX_W       = 3;

  // Input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Link status codes
  localparam logic [1:0] LINK_PENDING = 2'd0;
  localparam logic [1:0] LINK_UP      = 2'd1;
  localparam logic [1:0] LINK_FAILED  = 2'd2;

  // Roles
  localparam logic ROLE_TX = 1'b0;
  localparam logic ROLE_RX = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_ROLE     = 3'd0;
  localparam logic [2:0] REG_FLAG     = 3'd1;
  localparam logic [2:0] REG_ADDRESS  = 3'd2;
  localparam logic [2:0] REG_SET      = 3'd3;
  localparam logic [2:0] REG_UA       = 3'd4;
  localparam logic [2:0] REG_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_ATTEMPTS = 3'd6;

  // Recognizer phases
  localparam logic [2:0] PH_FLAG    = 3'd0;
  localparam logic [2:0] PH_ADDRESS = 3'd1;
  localparam logic [2:0] PH_CONTROL = 3'd2;
  localparam logic [2:0] PH_CHECK   = 3'd3;
  localparam logic [2:0] PH_END     = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] link_status;
  } out_item_t;

  typedef struct packed {
    logic        role;
    logic [7:0]  flag_byte;
    logic [7:0]  address_byte;
    logic [7:0]  set_code;
    logic [7:0]  ua_code;
    logic [15:0] timeout_ticks;
    logic [3:0]  max_attempts;
  } cfg_t;

  // One job for the back end: a full frame or a single status word
  typedef struct packed {
    logic       frame;
    logic [7:0] ctl;
    logic [1:0] link_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// ----- sv/sfls_front.sv -----
// Front end: accepts input words, runs the link state and issues jobs.
`default_nettype none
module sfls_front
  import sfls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire in_item_t item,
  output cmd_t          cmd
);

  logic [2:0]  phase, phase_next;
  logic        finished, finished_next;
  logic [3:0]  attempts, attempts_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic [7:0]  rec_ctl;
  logic [2:0]  rec_phase;
  logic        rec_hit;
  logic [15:0] idle_inc;

  // Frame recognizer step
  always_comb begin
    rec_ctl = (cfg.role == ROLE_RX) ? cfg.set_code : cfg.ua_code;
    rec_hit = 1'b0;
    unique case (phase)
      PH_ADDRESS: begin
        if (item.rx_byte == cfg.address_byte) rec_phase = PH_CONTROL;
        else if (item.rx_byte == cfg.flag_byte) rec_phase = PH_ADDRESS;
        else rec_phase = PH_FLAG;
      end
      PH_CONTROL: begin
        if (item.rx_byte == rec_ctl) rec_phase = PH_CHECK;
        else if (item.rx_byte == cfg.flag_byte) rec_phase = PH_ADDRESS;
        else rec_phase = PH_FLAG;
      end
      PH_CHECK: begin
        if (item.rx_byte == (rec_ctl ^ cfg.address_byte)) rec_phase = PH_END;
        else if (item.rx_byte == cfg.flag_byte) rec_phase = PH_ADDRESS;
        else rec_phase = PH_FLAG;
      end
      PH_END: begin
        rec_phase = PH_FLAG;
        rec_hit   = (item.rx_byte == cfg.flag_byte);
      end
      default: begin
        rec_phase = (item.rx_byte == cfg.flag_byte) ? PH_ADDRESS : PH_FLAG;
      end
    endcase
  end

  always_comb begin
    phase_next      = phase;
    finished_next   = finished;
    attempts_next   = attempts;
    idle_ticks_next = idle_ticks;
    cmd.frame       = 1'b0;
    cmd.ctl         = cfg.set_code;
    idle_inc        = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

    if (item.action == ACT_START) begin
      phase_next      = PH_FLAG;
      finished_next   = 1'b0;
      attempts_next   = 4'd0;
      idle_ticks_next = 16'd0;
      cmd.frame       = (cfg.role == ROLE_TX);
    end else if (cfg.role == ROLE_RX) begin
      if (item.action == ACT_BYTE) begin
        phase_next = rec_phase;
        if (rec_hit) begin
          finished_next = 1'b1;
          cmd.frame     = 1'b1;
          cmd.ctl       = cfg.ua_code;
        end
      end
    end else if (finished || (attempts >= cfg.max_attempts)) begin
      // link settled: hold state until the next start
    end else if (item.action == ACT_BYTE) begin
      idle_ticks_next = 16'd0;
      phase_next      = rec_phase;
      if (rec_hit) finished_next = 1'b1;
    end else if (item.action == ACT_TICK) begin
      if (idle_inc >= cfg.timeout_ticks) begin
        idle_ticks_next = 16'd0;
        phase_next      = PH_FLAG;
        attempts_next   = attempts + 4'd1;
        cmd.frame       = (attempts_next < cfg.max_attempts);
      end else begin
        idle_ticks_next = idle_inc;
      end
    end

    if (finished_next) cmd.link_status = LINK_UP;
    else if ((cfg.role == ROLE_TX) && (attempts_next >= cfg.max_attempts))
      cmd.link_status = LINK_FAILED;
    else cmd.link_status = LINK_PENDING;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      finished   <= 1'b0;
      attempts   <= 4'd0;
      idle_ticks <= 16'd0;
    end else if (accept) begin
      phase      <= phase_next;
      finished   <= finished_next;
      attempts   <= attempts_next;
      idle_ticks <= idle_ticks_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sfls_queue.sv -----
// Two-entry job queue between the front and back ends.
`default_nettype none
module sfls_queue
  import sfls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output queue_stat_t stat
);

  cmd_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- sv/sfls_back.sv -----
// Back end: expands queued jobs into output words behind an output register.
`default_nettype none
module sfls_back
  import sfls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire cmd_t        head,
  input  wire queue_stat_t qstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  logic             busy;
  cmd_t             cur;
  logic [IDX_W-1:0] idx;

  cmd_t             src;
  logic [IDX_W-1:0] src_idx;
  logic             advance;
  logic             src_last;
  logic [7:0]       frame_byte;

  always_comb begin
    src      = busy ? cur : head;
    src_idx  = busy ? idx : '0;
    advance  = (!out_valid || out_ready) && (busy || !qstat.empty);
    pop      = advance && !busy;
    src_last = !src.frame || (src_idx == IDX_W'(FRAME_BYTES - 1));
    unique case (src_idx)
      3'd1:    frame_byte = cfg.address_byte;
      3'd2:    frame_byte = src.ctl;
      3'd3:    frame_byte = cfg.address_byte ^ src.ctl;
      default: frame_byte = cfg.flag_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.tx_valid    <= src.frame;
      out_data.tx_byte     <= src.frame ? frame_byte : 8'd0;
      out_data.last        <= src_last;
      out_data.link_status <= src.link_status;
      cur                  <= src;
      idx                  <= src_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        busy      <= !src_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/supervision_frame_link_setup.sv -----
// Top level of the supervision frame link setup block.
//
// Channels: in_valid/in_ready carry one input word (start, received byte or
// timer tick); out_valid/out_ready carry result words. A start, or a timeout
// that leaves attempts, in transmitter role, or a complete SET in receiver role,
// yields a five-word frame (flag, address, control, check, flag) with last on
// the fifth word; every other input yields one status word with tx_valid low.
// Path: each input word's job goes through the job queue, then the output
// register. Throughput: a frame drains at one word per cycle while out_ready
// is high, so a frame input occupies the output for five words and a status
// input for one. The output word rate of the back end sets the throughput;
// the front end takes one word per cycle while the queue has room.
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock
// edge; write only while no results are pending.
// Reset (rst, synchronous): registers go to their defaults, the recognizer
// waits for a flag, the queue and output register empty.
// Receiver stall: the output word holds; the queue fills and then in_ready
// drops until the back end drains a job.
`default_nettype none
module supervision_frame_link_setup
  import sfls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  cfg_t        cfg;
  cmd_t        front_cmd;
  cmd_t        head;
  queue_stat_t qstat;
  logic        accept;
  logic        pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role          <= ROLE_TX;
      cfg.flag_byte     <= 8'd126;
      cfg.address_byte  <= 8'd3;
      cfg.set_code      <= 8'd3;
      cfg.ua_code       <= 8'd7;
      cfg.timeout_ticks <= 16'd3;
      cfg.max_attempts  <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROLE:     cfg.role          <= cfg_data[0];
        REG_FLAG:     cfg.flag_byte     <= cfg_data[7:0];
        REG_ADDRESS:  cfg.address_byte  <= cfg_data[7:0];
        REG_SET:      cfg.set_code      <= cfg_data[7:0];
        REG_UA:       cfg.ua_code       <= cfg_data[7:0];
        REG_TIMEOUT:  cfg.timeout_ticks <= cfg_data;
        REG_ATTEMPTS: cfg.max_attempts  <= cfg_data[3:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Take a word whenever the queue has room for its job
  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  sfls_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_data),
    .cmd    (front_cmd)
  );

  sfls_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  sfls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A status word is always a single, empty, final word
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.tx_valid) |-> (out_data.last && (out_data.tx_byte == 8'd0)))
    else $error("status word not final or not empty");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.link_status == LINK_PENDING) ||
                   (out_data.link_status == LINK_UP) ||
                   (out_data.link_status == LINK_FAILED)))
    else $error("invalid link status code");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- sim/supervision_frame_link_setup_tb.sv -----
// Self-checking testbench for the supervision frame link setup block.
`timescale 1ns / 1ps
module supervision_frame_link_setup_tb
  import sfls_pkg::*;
();

  // The fourth action code has no meaning; the block must answer it with status.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Ways to shape a frame sent into the recognizer
  localparam int FR_CLEAN       = 0;
  localparam int FR_CORRUPT     = 1;
  localparam int FR_TRUNC       = 2;
  localparam int FR_DOUBLE_FLAG = 3;

  localparam int ITEMS_TARGET = 430;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_GAP      = 17;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  supervision_frame_link_setup u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Words waiting to be offered, and result words the link should produce.
  in_item_t  pending_words[$];
  out_item_t expected_words[$];

  // Shadow of the configuration registers, tracked as they are written.
  cfg_t shadow = '{role: ROLE_TX, flag_byte: 8'd126, address_byte: 8'd3,
                   set_code: 8'd3, ua_code: 8'd7, timeout_ticks: 16'd3,
                   max_attempts: 4'd3};

  // Shadow of the link state: recognizer phase, established flag, timeouts
  // seen so far, and ticks since the last received byte.
  logic [2:0]  rcg_phase   = PH_FLAG;
  logic        link_done   = 1'b0;
  logic [3:0]  tries       = '0;
  logic [15:0] quiet_ticks = '0;

  int unsigned mismatches   = 0;
  int unsigned items_queued = 0;
  int unsigned cycle_count  = 0;

  // Handshake flags passed from the sampling edge to the driving edge.
  bit in_taken  = 0;
  bit out_taken = 0;
  int in_gap    = 0;
  int out_stall = 0;
  int hold_left = 0;
  bit hold_req  = 0;
  bit snd_burst = 0;
  bit rcv_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Link predictor
  // ---------------------------------------------------------------------------

  // Status seen on every result word, taken after the state update of the word.
  function automatic logic [1:0] link_state();
    if (link_done)
      return LINK_UP;
    if (shadow.role == ROLE_TX && tries >= shadow.max_attempts)
      return LINK_FAILED;
    return LINK_PENDING;
  endfunction

  task automatic queue_status();
    out_item_t w;
    w.tx_valid    = 1'b0;
    w.tx_byte     = 8'h00;
    w.last        = 1'b1;
    w.link_status = link_state();
    expected_words.push_back(w);
  endtask

  // Queue the five words of a supervision frame carrying the given control byte.
  task automatic queue_frame(logic [7:0] ctl);
    out_item_t  w;
    logic [7:0] f [FRAME_BYTES];
    f[0] = shadow.flag_byte;
    f[1] = shadow.address_byte;
    f[2] = ctl;
    f[3] = shadow.address_byte ^ ctl;
    f[4] = shadow.flag_byte;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      w.tx_valid    = 1'b1;
      w.tx_byte     = f[k];
      w.last        = (k == FRAME_BYTES - 1);
      w.link_status = link_state();
      expected_words.push_back(w);
    end
  endtask

  // Advance the frame recognizer by one byte; report a complete frame.
  function automatic bit match_byte(logic [7:0] b, logic [7:0] ctl);
    bit hit;
    hit = 1'b0;
    case (rcg_phase)
      PH_ADDRESS: begin
        rcg_phase = (b == shadow.address_byte) ? PH_CONTROL :
                    (b == shadow.flag_byte) ? PH_ADDRESS : PH_FLAG;
      end
      PH_CONTROL: begin
        rcg_phase = (b == ctl) ? PH_CHECK :
                    (b == shadow.flag_byte) ? PH_ADDRESS : PH_FLAG;
      end
      PH_CHECK: begin
        rcg_phase = (b == (ctl ^ shadow.address_byte)) ? PH_END :
                    (b == shadow.flag_byte) ? PH_ADDRESS : PH_FLAG;
      end
      PH_END: begin
        rcg_phase = PH_FLAG;
        hit = (b == shadow.flag_byte);
      end
      default: begin
        // Phases beyond the end behave like waiting for a flag
        rcg_phase = (b == shadow.flag_byte) ? PH_ADDRESS : PH_FLAG;
      end
    endcase
    return hit;
  endfunction

  task automatic predict_link(in_item_t it);
    if (it.action == ACT_START) begin
      rcg_phase   = PH_FLAG;
      link_done   = 1'b0;
      tries       = '0;
      quiet_ticks = '0;
      if (shadow.role == ROLE_TX)
        queue_frame(shadow.set_code);
      else
        queue_status();
    end else if (shadow.role == ROLE_RX) begin
      // Answer every complete SET, not only the first one
      if (it.action == ACT_BYTE && match_byte(it.rx_byte, shadow.set_code)) begin
        link_done = 1'b1;
        queue_frame(shadow.ua_code);
      end else begin
        queue_status();
      end
    end else if (link_done || tries >= shadow.max_attempts) begin
      // Transmitter is done until the next start
      queue_status();
    end else if (it.action == ACT_BYTE) begin
      quiet_ticks = '0;
      if (match_byte(it.rx_byte, shadow.ua_code))
        link_done = 1'b1;
      queue_status();
    end else if (it.action == ACT_TICK) begin
      if (quiet_ticks != 16'hFFFF)
        quiet_ticks = quiet_ticks + 16'd1;
      if (quiet_ticks >= shadow.timeout_ticks) begin
        quiet_ticks = '0;
        rcg_phase   = PH_FLAG;
        tries       = tries + 4'd1;
        if (tries < shadow.max_attempts)
          queue_frame(shadow.set_code);
        else
          queue_status();
      end else begin
        queue_status();
      end
    end else begin
      queue_status();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending words, with a random gap drawn after each accepted one
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    if (!rst && (!in_valid || in_taken)) begin
      if (in_taken) begin
        in_taken = 0;
        in_gap   = snd_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each result word outside bursts; honor a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (hold_req) begin
      hold_req  = 0;
      hold_left = HOLD_CYCLES;
    end
    if (out_taken) begin
      out_taken = 0;
      out_stall = rcv_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result words in order, then predict from accepted input words
  // ---------------------------------------------------------------------------
  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_taken = 1;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(out_data.tx_valid));
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("last", 8'(want.last), 8'(out_data.last));
          check_field("link_status", 8'(want.link_status), 8'(out_data.link_status));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1;
        predict_link(in_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic offer(logic [1:0] act, logic [7:0] b);
    in_item_t it;
    it.action  = act;
    it.rx_byte = b;
    pending_words.push_back(it);
    items_queued++;
  endtask

  // Send frame bytes into the recognizer, clean or deliberately damaged.
  task automatic offer_frame(logic [7:0] ctl, int mode);
    logic [7:0] f [FRAME_BYTES];
    int cut;
    int spot;
    f[0] = shadow.flag_byte;
    f[1] = shadow.address_byte;
    f[2] = ctl;
    f[3] = shadow.address_byte ^ ctl;
    f[4] = shadow.flag_byte;
    cut  = (mode == FR_TRUNC) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    spot = $urandom_range(0, FRAME_BYTES - 1);
    // Flip one bit so the damaged byte always differs from the clean one
    if (mode == FR_CORRUPT)
      f[spot] = f[spot] ^ (8'd1 << $urandom_range(0, 7));
    // A repeated opening flag must keep the recognizer waiting for the address
    if (mode == FR_DOUBLE_FLAG)
      offer(ACT_BYTE, shadow.flag_byte);
    for (int k = 0; k < cut; k++)
      offer(ACT_BYTE, f[k]);
  endtask

  // Favor bytes that mean something to the recognizer.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return shadow.flag_byte;
      1:       return shadow.address_byte;
      2:       return shadow.set_code;
      3:       return shadow.ua_code;
      4:       return shadow.address_byte ^ shadow.ua_code;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Write one register at the falling edge and mirror it in the shadow.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ROLE:     shadow.role          = val[0];
      REG_FLAG:     shadow.flag_byte     = val[7:0];
      REG_ADDRESS:  shadow.address_byte  = val[7:0];
      REG_SET:      shadow.set_code      = val[7:0];
      REG_UA:       shadow.ua_code       = val[7:0];
      REG_TIMEOUT:  shadow.timeout_ticks = val;
      REG_ATTEMPTS: shadow.max_attempts  = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick a setting for the next stretch of traffic and program all registers.
  task automatic setup_phase(int p);
    cfg_t c;
    c.role          = 1'($urandom_range(0, 1));
    c.flag_byte     = 8'($urandom_range(0, 255));
    c.address_byte  = ($urandom_range(0, 7) == 0) ? c.flag_byte :
                                                    8'($urandom_range(0, 255));
    c.set_code      = 8'($urandom_range(0, 255));
    c.ua_code       = ($urandom_range(0, 7) == 0) ? c.set_code :
                                                    8'($urandom_range(0, 255));
    c.timeout_ticks = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
                                                    16'($urandom_range(0, 6));
    c.max_attempts  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                                    4'($urandom_range(1, 5));
    case (p)
      0: begin
        // All-zero frame bytes, instant timeout, no attempts allowed
        c = '0;
        c.role = ROLE_TX;
      end
      1, 2: begin
        // All-ones frame bytes, slowest timeout, most attempts, both roles
        c.role          = (p == 1) ? ROLE_RX : ROLE_TX;
        c.flag_byte     = 8'hFF;
        c.address_byte  = 8'hFF;
        c.set_code      = 8'hFF;
        c.ua_code       = 8'hFF;
        c.timeout_ticks = 16'hFFFF;
        c.max_attempts  = 4'hF;
      end
      3: begin
        c.role          = ROLE_TX;
        c.timeout_ticks = 16'd1;
        c.max_attempts  = 4'd1;
      end
      4: begin
        c.role          = ROLE_TX;
        c.timeout_ticks = 16'd0;
        c.max_attempts  = 4'hF;
      end
      5: begin
        c.role         = ROLE_RX;
        c.flag_byte    = 8'h00;
        c.address_byte = 8'h00;
        c.set_code     = 8'h00;
        c.ua_code      = 8'h00;
      end
      default: ;
    endcase
    write_reg(REG_ROLE, 16'(c.role));
    write_reg(REG_FLAG, 16'(c.flag_byte));
    write_reg(REG_ADDRESS, 16'(c.address_byte));
    write_reg(REG_SET, 16'(c.set_code));
    write_reg(REG_UA, 16'(c.ua_code));
    write_reg(REG_TIMEOUT, c.timeout_ticks);
    write_reg(REG_ATTEMPTS, 16'(c.max_attempts));
    @(posedge clk);
    // Flood the input during the hold-off stretch so the block backs up
    snd_burst = (p == 3) || ($urandom_range(0, 3) == 0);
    rcv_burst = (p != 3) && ($urandom_range(0, 3) == 0);
  endtask

  // Frames of the kind the current role waits for, mostly clean, mixed with
  // restarts, tick runs, damaged frames, frames of the other kind and noise.
  task automatic stir(int count);
    int unsigned stop;
    int r;
    int run;
    int mode;
    logic [7:0] own_ctl;
    logic [7:0] other_ctl;
    stop      = items_queued + count;
    own_ctl   = (shadow.role == ROLE_TX) ? shadow.ua_code : shadow.set_code;
    other_ctl = (shadow.role == ROLE_TX) ? shadow.set_code : shadow.ua_code;
    run       = (shadow.timeout_ticks > 0 && shadow.timeout_ticks <= 8) ?
                int'(shadow.timeout_ticks) : 3;
    while (items_queued < stop) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        offer(ACT_START, 8'($urandom_range(0, 255)));
      end else if (r < 40) begin
        case ($urandom_range(0, 7))
          4:       mode = FR_CORRUPT;
          5:       mode = FR_TRUNC;
          6:       mode = FR_DOUBLE_FLAG;
          default: mode = FR_CLEAN;
        endcase
        offer_frame(own_ctl, mode);
      end else if (r < 47) begin
        offer_frame(other_ctl, FR_CLEAN);
      end else if (r < 72) begin
        repeat ($urandom_range(1, run + 1))
          offer(ACT_TICK, 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        offer(ACT_BYTE, pick_byte());
      end else begin
        offer(ACT_UNUSED, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every word is accepted and every result has come back.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_no;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: ticks before any start time out and send SET
    repeat (3) offer(ACT_TICK, 8'h00);
    // Start, then a UA frame behind a repeated flag establishes the link
    offer(ACT_START, 8'hFF);
    offer_frame(shadow.ua_code, FR_DOUBLE_FLAG);
    // Established link ignores bytes, ticks and the unused action
    offer(ACT_BYTE, 8'h00);
    offer(ACT_TICK, 8'hFF);
    offer(ACT_UNUSED, 8'hFF);
    // Restart and let every attempt time out until the link gives up
    offer(ACT_START, 8'h00);
    repeat (9) offer(ACT_TICK, 8'($urandom_range(0, 255)));
    drain();

    // Receiver role: start gives status, a SET frame is answered with UA
    write_reg(REG_ROLE, 16'(ROLE_RX));
    @(posedge clk);
    offer(ACT_START, 8'hA5);
    offer_frame(shadow.set_code, FR_CLEAN);
    drain();

    // Random traffic, one register setting per phase
    phase_no = 0;
    while (items_queued < ITEMS_TARGET) begin
      setup_phase(phase_no);
      stir(45);
      if (phase_no == 3)
        hold_req = 1;
      drain();
      phase_no++;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
